// ===== hw/rtl/bfbs_pkg.sv =====
`default_nettype none

package bfbs_pkg;

	localparam int DIM_W = 16;
	localparam int THK_W = 15;
	localparam int IDX_W = 10;
	localparam int KEY_W = 3 * DIM_W;
	localparam int NUM_ORIENT = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [KEY_W-1:0] KEY_ONES = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_WIDTH       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_HEIGHT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_DEPTH       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYER_THICKNESS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DEPTH    = 3'd4;

	typedef struct packed {
		logic [DIM_W-1:0] gap_width;
		logic [DIM_W-1:0] gap_height;
		logic [DIM_W-1:0] gap_depth;
		logic [THK_W-1:0] layer_thickness;
		logic [THK_W-1:0] target_depth;
	} cfg_t;

	// One candidate placement: a box in a given orientation with its ranking key.
	// A candidate that does not qualify carries the all-ones key.
	typedef struct packed {
		logic             hit;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] d;
	} cand_t;

	typedef struct packed {
		cand_t fit;
		cand_t over;
	} orient_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] d;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfbs_orient.sv =====
`default_nettype none

module bfbs_orient (
	input  var bfbs_pkg::cfg_t                cfg,
	input  wire                               live,
	input  wire  [bfbs_pkg::IDX_W-1:0]        idx,
	input  wire  [bfbs_pkg::DIM_W-1:0]        w,
	input  wire  [bfbs_pkg::DIM_W-1:0]        h,
	input  wire  [bfbs_pkg::DIM_W-1:0]        d,
	output bfbs_pkg::orient_t                 cand
);

	logic [bfbs_pkg::DIM_W-1:0] lt;
	logic [bfbs_pkg::DIM_W-1:0] td;
	logic [bfbs_pkg::DIM_W-1:0] hk;
	logic [bfbs_pkg::DIM_W-1:0] wx;
	logic [bfbs_pkg::DIM_W-1:0] dz;
	logic                       fits;
	logic                       in_layer;
	logic [bfbs_pkg::KEY_W-1:0] key;

	always_comb begin
		lt       = {1'b0, cfg.layer_thickness};
		td       = {1'b0, cfg.target_depth};
		fits     = (w <= cfg.gap_width) && (h <= cfg.gap_height) && (d <= cfg.gap_depth);
		in_layer = (h <= lt);
		hk       = in_layer ? (lt - h) : (h - lt);
		wx       = cfg.gap_width - w;
		dz       = (td >= d) ? (td - d) : (d - td);
		key      = {hk, wx, dz};

		cand.fit.hit  = live && fits && in_layer;
		cand.fit.key  = cand.fit.hit ? key : bfbs_pkg::KEY_ONES;
		cand.fit.idx  = idx;
		cand.fit.w    = w;
		cand.fit.h    = h;
		cand.fit.d    = d;

		cand.over.hit = live && fits && !in_layer;
		cand.over.key = cand.over.hit ? key : bfbs_pkg::KEY_ONES;
		cand.over.idx = idx;
		cand.over.w   = w;
		cand.over.h   = h;
		cand.over.d   = d;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bfbs_pick.sv =====
`default_nettype none

// Keeps the earlier candidate unless the later one has a strictly smaller key.
module bfbs_pick (
	input  var bfbs_pkg::cand_t early,
	input  var bfbs_pkg::cand_t late,
	output bfbs_pkg::cand_t     best
);

	assign best = (late.key < early.key) ? late : early;

endmodule

`default_nettype wire

// ===== hw/rtl/bfbs_accum.sv =====
`default_nettype none

module bfbs_accum (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 valid,
	input  wire                 last,
	input  var bfbs_pkg::cand_t fit_cand,
	input  var bfbs_pkg::cand_t over_cand,
	output logic                ready,
	output logic                out_valid,
	input  wire                 out_stall,
	output bfbs_pkg::res_t      fit_res,
	output bfbs_pkg::res_t      over_res
);

	bfbs_pkg::cand_t fit_best_q;
	bfbs_pkg::cand_t over_best_q;
	bfbs_pkg::cand_t fit_next;
	bfbs_pkg::cand_t over_next;
	bfbs_pkg::cand_t clear_best;
	bfbs_pkg::res_t  fit_res_q;
	bfbs_pkg::res_t  over_res_q;
	logic            out_valid_q;
	logic            take;

	bfbs_pick u_fit_pick (
		.early (fit_best_q),
		.late  (fit_cand),
		.best  (fit_next)
	);

	bfbs_pick u_over_pick (
		.early (over_best_q),
		.late  (over_cand),
		.best  (over_next)
	);

	always_comb begin
		clear_best     = '0;
		clear_best.key = bfbs_pkg::KEY_ONES;
		// A closing word needs the output register free; any other word never waits.
		take  = valid && (!last || !out_valid_q || !out_stall);
		ready = !valid || take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_best_q  <= clear_best;
			over_best_q <= clear_best;
			out_valid_q <= 1'b0;
		end else begin
			if (take && last) begin
				fit_best_q  <= clear_best;
				over_best_q <= clear_best;
				out_valid_q <= 1'b1;
			end else begin
				if (take) begin
					fit_best_q  <= fit_next;
					over_best_q <= over_next;
				end
				if (!out_stall) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			fit_res_q  <= '{found: fit_next.hit, idx: fit_next.idx,
				w: fit_next.w, h: fit_next.h, d: fit_next.d};
			over_res_q <= '{found: over_next.hit, idx: over_next.idx,
				w: over_next.w, h: over_next.h, d: over_next.d};
		end
	end

	assign out_valid = out_valid_q;
	assign fit_res   = fit_res_q;
	assign over_res  = over_res_q;

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take && last |=> out_valid_q)
		else $error("closing word did not raise the result valid");

	a_emit_clears_bests: assert property (@(posedge clk) disable iff (!arst_n)
		take && last |=> !fit_best_q.hit && !over_best_q.hit)
		else $error("running bests not cleared after a result");

	a_no_hit_key_ones: assert property (@(posedge clk) disable iff (!arst_n)
		!fit_best_q.hit |-> fit_best_q.key == bfbs_pkg::KEY_ONES
		&& fit_best_q.w == '0 && fit_best_q.idx == '0)
		else $error("empty in-layer best holds a key or a choice");

	a_no_winner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !over_res_q.found |-> over_res_q.idx == '0
		&& over_res_q.w == '0 && over_res_q.h == '0 && over_res_q.d == '0)
		else $error("over-layer result without a winner is not zero");

	a_full_blocks_close: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last && out_valid_q && out_stall |-> !take)
		else $error("result overwritten while still waiting");

endmodule

`default_nettype wire

// ===== hw/rtl/best_fit_box_select.sv =====
// Best-fit box selector for one gap of a layer-based 3D packer.
// Configuration: write gap_width, gap_height, gap_depth, layer_thickness and
// target_depth through cfg_we / cfg_index / cfg_wdata while the block is idle.
// Input channel: one word per candidate box (dimensions, index, packed flag,
// last mark), taken on a clock edge with in_valid high and in_stall low.
// Packed boxes are skipped; every other box is tried in all six orientations
// and the best in-layer and best over-layer placements are kept.
// Output channel: one word per search, produced by the box marked last_box,
// carrying both winners; it is taken when out_valid is high and out_stall low.
// Path: an accepted box sits in the input register, where its orientation
// keys, the picks and the merge into the running bests are all worked out
// combinationally; the result word is then held in the result register and
// offered from there. Throughput: one box per cycle unless a last box waits.
// When the receiver stalls, boxes that are not last keep flowing and are
// merged into the running bests; only a last box waits in the input register
// for the result register to be taken, and the input stalls meanwhile.
// Reset clears the configuration to zero, empties the input register and
// clears the running bests; no result is pending after reset.
`default_nettype none

module best_fit_box_select (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [bfbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [bfbs_pkg::DIM_W-1:0]    cfg_wdata,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire [bfbs_pkg::DIM_W-1:0]    box_x,
	input  wire [bfbs_pkg::DIM_W-1:0]    box_y,
	input  wire [bfbs_pkg::DIM_W-1:0]    box_z,
	input  wire [bfbs_pkg::IDX_W-1:0]    box_index,
	input  wire                          box_packed,
	input  wire                          last_box,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         fit_found,
	output logic [bfbs_pkg::IDX_W-1:0]   fit_index,
	output logic [bfbs_pkg::DIM_W-1:0]   fit_width,
	output logic [bfbs_pkg::DIM_W-1:0]   fit_height,
	output logic [bfbs_pkg::DIM_W-1:0]   fit_depth,
	output logic                         over_found,
	output logic [bfbs_pkg::IDX_W-1:0]   over_index,
	output logic [bfbs_pkg::DIM_W-1:0]   over_width,
	output logic [bfbs_pkg::DIM_W-1:0]   over_height,
	output logic [bfbs_pkg::DIM_W-1:0]   over_depth
);

	localparam int NO = bfbs_pkg::NUM_ORIENT;
	localparam int NP = NO / 2;

	// Configuration registers.
	bfbs_pkg::cfg_t cfg_q;

	// Stage 1: the accepted box word.
	logic                       v_s1;
	logic                       last_s1;
	logic                       packed_s1;
	logic [bfbs_pkg::DIM_W-1:0] x_s1;
	logic [bfbs_pkg::DIM_W-1:0] y_s1;
	logic [bfbs_pkg::DIM_W-1:0] z_s1;
	logic [bfbs_pkg::IDX_W-1:0] idx_s1;

	logic adv1;
	logic merge_ready;

	logic [bfbs_pkg::DIM_W-1:0] w_o [NO];
	logic [bfbs_pkg::DIM_W-1:0] h_o [NO];
	logic [bfbs_pkg::DIM_W-1:0] d_o [NO];
	bfbs_pkg::orient_t          or_c [NO];
	bfbs_pkg::cand_t            fit_pair  [NP];
	bfbs_pkg::cand_t            over_pair [NP];
	bfbs_pkg::cand_t            fit_ab, over_ab, fit_box, over_box;
	bfbs_pkg::res_t             fit_res, over_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bfbs_pkg::CFG_GAP_WIDTH:       cfg_q.gap_width <= cfg_wdata;
				bfbs_pkg::CFG_GAP_HEIGHT:      cfg_q.gap_height <= cfg_wdata;
				bfbs_pkg::CFG_GAP_DEPTH:       cfg_q.gap_depth <= cfg_wdata;
				bfbs_pkg::CFG_LAYER_THICKNESS: begin
					cfg_q.layer_thickness <= cfg_wdata[bfbs_pkg::THK_W-1:0];
				end
				bfbs_pkg::CFG_TARGET_DEPTH:    begin
					cfg_q.target_depth <= cfg_wdata[bfbs_pkg::THK_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// The input register moves on when it is empty or the merge takes its word.
	assign adv1     = !v_s1 || merge_ready;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			x_s1      <= box_x;
			y_s1      <= box_y;
			z_s1      <= box_z;
			idx_s1    <= box_index;
			packed_s1 <= box_packed;
			last_s1   <= last_box;
		end
	end

	// The six orientations as (width, height, depth), in trial order. For a cube
	// they are all the same, so trying all of them changes nothing.
	always_comb begin
		w_o[0] = x_s1; h_o[0] = y_s1; d_o[0] = z_s1;
		w_o[1] = x_s1; h_o[1] = z_s1; d_o[1] = y_s1;
		w_o[2] = y_s1; h_o[2] = x_s1; d_o[2] = z_s1;
		w_o[3] = y_s1; h_o[3] = z_s1; d_o[3] = x_s1;
		w_o[4] = z_s1; h_o[4] = x_s1; d_o[4] = y_s1;
		w_o[5] = z_s1; h_o[5] = y_s1; d_o[5] = x_s1;
	end

	for (genvar o = 0; o < NO; o++) begin : g_orient
		bfbs_orient u_orient (
			.cfg  (cfg_q),
			.live (!packed_s1),
			.idx  (idx_s1),
			.w    (w_o[o]),
			.h    (h_o[o]),
			.d    (d_o[o]),
			.cand (or_c[o])
		);
	end

	// Picking the earlier candidate on equal keys keeps trial order throughout.
	for (genvar p = 0; p < NP; p++) begin : g_pair
		bfbs_pick u_fit_pair (
			.early (or_c[2*p].fit),
			.late  (or_c[2*p+1].fit),
			.best  (fit_pair[p])
		);
		bfbs_pick u_over_pair (
			.early (or_c[2*p].over),
			.late  (or_c[2*p+1].over),
			.best  (over_pair[p])
		);
	end

	bfbs_pick u_fit_ab (.early(fit_pair[0]), .late(fit_pair[1]), .best(fit_ab));
	bfbs_pick u_fit_c  (.early(fit_ab),      .late(fit_pair[2]), .best(fit_box));
	bfbs_pick u_over_ab (.early(over_pair[0]), .late(over_pair[1]), .best(over_ab));
	bfbs_pick u_over_c  (.early(over_ab),      .late(over_pair[2]), .best(over_box));

	// Running bests and the result register.
	bfbs_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (v_s1),
		.last      (last_s1),
		.fit_cand  (fit_box),
		.over_cand (over_box),
		.ready     (merge_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.fit_res   (fit_res),
		.over_res  (over_res)
	);

	assign fit_found   = fit_res.found;
	assign fit_index   = fit_res.idx;
	assign fit_width   = fit_res.w;
	assign fit_height  = fit_res.h;
	assign fit_depth   = fit_res.d;
	assign over_found  = over_res.found;
	assign over_index  = over_res.idx;
	assign over_width  = over_res.w;
	assign over_height = over_res.h;
	assign over_depth  = over_res.d;

endmodule

`default_nettype wire
